>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on rising edge.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

>>> hdl/ppg_pkg.sv
// ----------------------------------------------------------------------------
// ppg_pkg
// Types and constants for the pin pulse generator.
// ----------------------------------------------------------------------------
package ppg_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int DUR_W         = 32;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int IN_DATA_W     = 8;
    localparam int OUT_DATA_W    = 8;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_TRIGGER = 3'd1,
        OP_ENABLE  = 3'd2,
        OP_DISABLE = 3'd3,
        OP_FORCE   = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        MODE_ONESHOT = 2'd0,
        MODE_CONT    = 2'd1,
        MODE_BURST   = 2'd2,
        MODE_SPARE   = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HIGH_TIME  = 2'd0,
        REG_LOW_TIME   = 2'd1,
        REG_MODE       = 2'd2,
        REG_IDLE_LEVEL = 2'd3
    } t_reg_idx;

    localparam logic [1:0] PULSE_TWO  = 2'd2;
    localparam logic [1:0] PULSE_DONE = 2'd3;

    typedef struct packed {
        logic pin_level;
        logic edge_res;
    } t_result;

endpackage

>>> hdl/pin_pulse_generator.sv
// ----------------------------------------------------------------------------
// pin_pulse_generator: one-shot / continuous / burst pin level generator
// Result is registered in the output register; one item per cycle unless the output stalls.
// Output register plus skid stage decouple input and output handshakes.
// Synchronous active-low reset initialises state and clears config and valid flags.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pin_pulse_generator
    import ppg_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [2:0] opcode, [3] write_level
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [0] pin_level, [1] edge_res
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int CMP_W = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;
    localparam logic [TIME_BITS-1:0] ELAPSED_MAX = {TIME_BITS{1'b1}};

    logic [DUR_W-1:0]     r_high_time;
    logic [DUR_W-1:0]     r_low_time;
    t_mode                r_mode;
    logic                 r_idle;

    logic                 r_level,   n_level;
    logic [TIME_BITS-1:0] r_elapsed, n_elapsed;
    logic [1:0]           r_pulse,   n_pulse;
    logic                 r_running, n_running;
    logic                 r_trig,    n_trig;
    logic                 r_first;
    logic                 n_edge;

    logic                 r_out_valid;
    t_result              r_out_data;
    logic                 r_skid_valid;
    t_result              r_skid_data;

    t_opcode              in_op;
    logic                 in_wl;
    logic                 in_acc;
    logic                 out_take;
    logic [TIME_BITS-1:0] elapsed_inc;
    logic                 high_done;
    logic                 low_done;
    logic                 chg;
    t_result              new_res;

    assign in_op         = t_opcode'(s_axis_tdata[2:0]);
    assign in_wl         = s_axis_tdata[3];
    assign s_axis_tready = !r_skid_valid;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_take      = r_out_valid && m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-2){1'b0}}, r_out_data.edge_res, r_out_data.pin_level};

    assign elapsed_inc = (r_elapsed == ELAPSED_MAX) ? r_elapsed
                                                    : r_elapsed + {{(TIME_BITS-1){1'b0}}, 1'b1};
    assign high_done   = CMP_W'(elapsed_inc) >= CMP_W'(r_high_time);
    assign low_done    = CMP_W'(elapsed_inc) >= CMP_W'(r_low_time);

    // tick evaluation
    always_comb begin
        n_level   = r_level;
        n_pulse   = r_pulse;
        n_trig    = r_trig;
        chg       = 1'b0;
        case (r_mode)
            MODE_CONT, MODE_BURST: begin
                if (!(r_level == r_idle && !r_running)) begin
                    if (r_mode == MODE_CONT) begin
                        if (r_level) begin
                            if (high_done) begin
                                chg     = 1'b1;
                                n_level = 1'b0;
                            end
                        end else if (low_done) begin
                            chg     = 1'b1;
                            n_level = 1'b1;
                        end
                    end else begin
                        if (r_level) begin
                            if (high_done && r_pulse != PULSE_DONE) begin
                                chg     = 1'b1;
                                n_level = 1'b0;
                                if (r_pulse == PULSE_TWO) begin
                                    n_pulse = PULSE_DONE;
                                end
                            end
                        end else if ((low_done || r_first) && r_pulse < PULSE_TWO) begin
                            chg     = 1'b1;
                            n_level = 1'b1;
                            n_pulse = r_pulse + 2'd1;
                        end
                    end
                end
            end
            default: begin
                if (r_level != r_idle) begin
                    if ((!r_idle && low_done) || (r_idle && high_done)) begin
                        chg     = 1'b1;
                        n_level = r_idle;
                    end
                end else if (r_trig) begin
                    chg     = 1'b1;
                    n_level = !r_idle;
                    n_trig  = 1'b0;
                end
            end
        endcase
    end

    // command decode
    logic                 c_level;
    logic [TIME_BITS-1:0] c_elapsed;
    logic [1:0]           c_pulse;
    logic                 c_trig;
    logic                 c_first;

    always_comb begin
        c_level   = r_level;
        c_elapsed = r_elapsed;
        c_pulse   = r_pulse;
        c_trig    = r_trig;
        c_first   = r_first;
        n_running = r_running;
        n_edge    = 1'b0;
        n_elapsed = r_elapsed;
        unique case (in_op)
            OP_TICK: begin
                c_level   = n_level;
                c_pulse   = n_pulse;
                c_trig    = n_trig;
                c_elapsed = chg ? '0 : elapsed_inc;
                c_first   = chg ? 1'b0 : r_first;
                n_edge    = chg;
            end
            OP_TRIGGER: c_trig    = 1'b1;
            OP_ENABLE:  n_running = 1'b1;
            OP_DISABLE: begin
                n_running = 1'b0;
                c_pulse   = '0;
            end
            OP_FORCE:   c_level   = in_wl;
            default: ;
        endcase
        n_elapsed         = c_elapsed;
        new_res.pin_level = c_level;
        new_res.edge_res  = n_edge;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_time <= '0;
            r_low_time  <= '0;
            r_mode      <= MODE_ONESHOT;
            r_idle      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_HIGH_TIME:  r_high_time <= i_cfg_wdata[DUR_W-1:0];
                REG_LOW_TIME:   r_low_time  <= i_cfg_wdata[DUR_W-1:0];
                REG_MODE:       r_mode      <= t_mode'(i_cfg_wdata[1:0]);
                REG_IDLE_LEVEL: r_idle      <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= 1'b0;
            r_elapsed <= '0;
            r_pulse   <= '0;
            r_running <= 1'b0;
            r_trig    <= 1'b0;
            r_first   <= 1'b1;
        end else if (in_acc) begin
            r_level   <= c_level;
            r_elapsed <= n_elapsed;
            r_pulse   <= c_pulse;
            r_running <= n_running;
            r_trig    <= c_trig;
            r_first   <= c_first;
        end
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_acc;
            end
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            r_out_data <= r_skid_valid ? r_skid_data : new_res;
        end else if (in_acc) begin
            r_skid_data <= new_res;
        end
    end

    `ASSERT_SAME(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `ASSERT_NEXT(a_edge_restarts, i_clk, i_rst_n, in_acc && n_edge, r_elapsed == '0 && !r_first)
    `ASSERT_NEXT(a_disable_clears, i_clk, i_rst_n, in_acc && in_op == OP_DISABLE, r_pulse == '0 && !r_running)

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for pin_pulse_generator
// Sends tick and command transfers over the input stream and checks each
// result transfer against a cycle-free model of the pin level logic. Runs
// directed sequences for reset defaults, burst start and end, and spare mode as
// one-shot with high idle, then random phases with fresh register settings.
// ----------------------------------------------------------------------------
module tb_top;
    import ppg_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int RAND_ITEMS  = 850;

    typedef struct packed {
        logic       wl;
        logic [2:0] op;
    } t_cmd;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [2:0] opcode, [3] write_level
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // [0] pin_level, [1] edge_res
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;

    pin_pulse_generator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // model registers and state
    logic [DUR_W-1:0]     cfg_high = '0;
    logic [DUR_W-1:0]     cfg_low  = '0;
    t_mode                cfg_mode = MODE_ONESHOT;
    logic                 cfg_idle = 1'b0;
    logic                 m_level   = 1'b0;
    logic [TIME_BITS_DEF-1:0] m_elapsed = '0;
    logic [1:0]           m_pulses  = '0;
    logic                 m_running = 1'b0;
    logic                 m_trig    = 1'b0;
    logic                 m_first   = 1'b1;

    t_cmd    cmd_q[$];
    t_result pin_q[$];
    bit      sent_fire    = 0;
    bit      hold_tx      = 0;
    bit      calm         = 0;
    int      n_err        = 0;
    int      stall_cycles = 0;

    function automatic t_result pin_step(input logic [2:0] op, input logic wl);
        t_result r;
        logic    hi_done;
        logic    lo_done;
        logic    nxt;
        r.edge_res = 1'b0;
        case (op)
            OP_TICK: begin
                if (m_elapsed != '1)
                    m_elapsed = m_elapsed + 1'b1;
                hi_done = (m_elapsed >= cfg_high);
                lo_done = (m_elapsed >= cfg_low);
                nxt     = m_level;
                if (cfg_mode == MODE_CONT || cfg_mode == MODE_BURST) begin
                    if (m_level != cfg_idle || m_running) begin
                        if (m_level) begin
                            if (hi_done && (cfg_mode == MODE_CONT || m_pulses != PULSE_DONE)) begin
                                nxt = 1'b0;
                                if (cfg_mode == MODE_BURST && m_pulses == PULSE_TWO)
                                    m_pulses = PULSE_DONE;
                            end
                        end else if (cfg_mode == MODE_CONT) begin
                            if (lo_done)
                                nxt = 1'b1;
                        end else if ((lo_done || m_first) && m_pulses < PULSE_TWO) begin
                            nxt      = 1'b1;
                            m_pulses = m_pulses + 1'b1;
                        end
                    end
                end else if (m_level != cfg_idle) begin
                    if (cfg_idle ? hi_done : lo_done)
                        nxt = cfg_idle;
                end else if (m_trig) begin
                    nxt    = ~cfg_idle;
                    m_trig = 1'b0;
                end
                if (nxt != m_level) begin
                    m_level    = nxt;
                    m_elapsed  = '0;
                    m_first    = 1'b0;
                    r.edge_res = 1'b1;
                end
            end
            OP_TRIGGER: m_trig = 1'b1;
            OP_ENABLE:  m_running = 1'b1;
            OP_DISABLE: begin
                m_running = 1'b0;
                m_pulses  = '0;
            end
            OP_FORCE:   m_level = wl;
            default: ;
        endcase
        r.pin_level = m_level;
        return r;
    endfunction

    // stimulus drive, both handshake sides
    always @(negedge i_clk) begin
        int gap_pct;
        t_cmd c;
        gap_pct = calm ? 0 : 15;
        if (!s_axis_tvalid || sent_fire) begin
            if (cmd_q.size() > 0 && !hold_tx && $urandom_range(0, 99) >= gap_pct) begin
                c = cmd_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= IN_DATA_W'(c);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= gap_pct);
    end

    // result check and prediction
    always @(posedge i_clk) begin
        t_result want;
        bit in_fire;
        bit out_fire;
        in_fire   = i_rst_n && s_axis_tvalid && s_axis_tready;
        out_fire  = i_rst_n && m_axis_tvalid && m_axis_tready;
        sent_fire = in_fire;
        if (out_fire) begin
            if (pin_q.size() == 0) begin
                $error("result transfer with no pending prediction");
                n_err++;
            end else begin
                want = pin_q.pop_front();
                if (m_axis_tdata[0] !== want.pin_level) begin
                    $error("pin_level expected %0b actual %0b", want.pin_level, m_axis_tdata[0]);
                    n_err++;
                end
                if (m_axis_tdata[1] !== want.edge_res) begin
                    $error("edge_res expected %0b actual %0b", want.edge_res, m_axis_tdata[1]);
                    n_err++;
                end
            end
        end
        if (in_fire)
            pin_q.push_back(pin_step(s_axis_tdata[2:0], s_axis_tdata[3]));
        if (!i_rst_n || in_fire || out_fire || i_cfg_we)
            stall_cycles = 0;
        else
            stall_cycles++;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            REG_HIGH_TIME:  cfg_high = val;
            REG_LOW_TIME:   cfg_low  = val;
            REG_MODE:       cfg_mode = t_mode'(val[1:0]);
            REG_IDLE_LEVEL: cfg_idle = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [DUR_W-1:0] hi, input logic [DUR_W-1:0] lo,
                              input t_mode md, input logic idle);
        write_reg(REG_HIGH_TIME, hi);
        write_reg(REG_LOW_TIME, lo);
        write_reg(REG_MODE, CFG_DATA_W'(md));
        write_reg(REG_IDLE_LEVEL, CFG_DATA_W'(idle));
        @(posedge i_clk);
    endtask

    task automatic push_cmd(input logic [2:0] op, input logic wl);
        t_cmd c;
        c.op = op;
        c.wl = wl;
        cmd_q.push_back(c);
    endtask

    // waits until the stream is empty and every prediction is matched
    task automatic wait_idle();
        @(negedge i_clk);
        while (cmd_q.size() != 0 || s_axis_tvalid || pin_q.size() != 0)
            @(negedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    function automatic logic [DUR_W-1:0] pick_dur();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return DUR_W'($urandom_range(0, 4));
        else if (r < 90)
            return DUR_W'($urandom_range(5, 40));
        else if (r < 95)
            return '1;
        return DUR_W'($urandom);
    endfunction

    function automatic t_cmd rand_cmd(input t_mode md);
        t_cmd c;
        int   r;
        int   trig_w;
        trig_w = (md == MODE_ONESHOT || md == MODE_SPARE) ? 15 : 5;
        r      = $urandom_range(0, 99);
        c.wl   = 1'($urandom_range(0, 1));
        if (r < 65)
            c.op = OP_TICK;
        else if (r < 65 + trig_w)
            c.op = OP_TRIGGER;
        else if (r < 72 + trig_w)
            c.op = OP_ENABLE;
        else if (r < 78 + trig_w)
            c.op = OP_DISABLE;
        else if (r < 96)
            c.op = OP_FORCE;
        else
            c.op = 3'(OP_FORCE + $urandom_range(1, 3));
        return c;
    endfunction

    task automatic random_phase(input int n, input bit pause_mid, input bit quiet);
        t_mode md;
        md = t_mode'($urandom_range(0, 3));
        set_config(pick_dur(), pick_dur(), md, 1'($urandom_range(0, 1)));
        calm = quiet;
        if ((md == MODE_CONT || md == MODE_BURST) && $urandom_range(0, 9) != 0)
            push_cmd(OP_ENABLE, 1'($urandom_range(0, 1)));
        repeat (n)
            cmd_q.push_back(rand_cmd(md));
        if (pause_mid) begin
            @(negedge i_clk);
            while (cmd_q.size() > n / 2)
                @(negedge i_clk);
            @(posedge i_clk);
            hold_tx = 1;
            @(negedge i_clk);
            while (s_axis_tvalid || pin_q.size() != 0)
                @(negedge i_clk);
            @(posedge i_clk);
            hold_tx = 0;
        end
        wait_idle();
        calm = 0;
    endtask

    initial begin
        int n_rand;
        int phase;
        int n;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: one-shot, idle low, zero durations
        push_cmd(OP_TICK, 1'b0);
        push_cmd(OP_FORCE, 1'b1);
        push_cmd(OP_FORCE, 1'b0);
        push_cmd(3'(OP_FORCE + 1), 1'b1);
        push_cmd(3'(OP_FORCE + 2), 1'b0);
        push_cmd(3'(OP_FORCE + 3), 1'b1);
        push_cmd(OP_ENABLE, 1'b0);
        wait_idle();

        // burst start: first low phase already elapsed despite maximum low time
        set_config('0, '1, MODE_BURST, 1'b0);
        push_cmd(OP_DISABLE, 1'b0);
        push_cmd(OP_TICK, 1'b0);
        push_cmd(OP_ENABLE, 1'b1);
        push_cmd(OP_TICK, 1'b0);
        push_cmd(OP_TICK, 1'b1);
        push_cmd(OP_TICK, 1'b0);
        wait_idle();

        // burst end: second pulse, then stays low
        set_config('0, '0, MODE_BURST, 1'b0);
        push_cmd(OP_TICK, 1'b0);
        push_cmd(OP_TICK, 1'b1);
        push_cmd(OP_TICK, 1'b0);
        wait_idle();

        // spare mode acts as one-shot, idle high
        set_config(DUR_W'(1), '1, MODE_SPARE, 1'b1);
        push_cmd(OP_TICK, 1'b0);
        push_cmd(OP_TRIGGER, 1'b0);
        push_cmd(OP_TICK, 1'b1);
        push_cmd(OP_TICK, 1'b0);
        wait_idle();

        n_rand = 0;
        phase  = 0;
        while (n_rand < RAND_ITEMS) begin
            n = (phase == 3) ? 150 : $urandom_range(30, 60);
            random_phase(n, phase == 6, phase == 3);
            n_rand += n;
            phase++;
        end

        repeat (5) @(posedge i_clk);
        if (pin_q.size() != 0) begin
            $error("%0d predicted results never arrived", pin_q.size());
            n_err++;
        end
        if (n_err == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
